/* design/assert_macros.svh */
// Assertion macros for the reader MAC core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst_n, ante, cons)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/samac_pkg.sv */
// Shared types and constants for the reader MAC core
package samac_pkg;
	localparam int MAX_PAIRS_DEF = 8;
	localparam logic [1:0] ACK  = 2'd1;
	localparam logic [1:0] NACK = 2'd2;
	localparam logic [1:0] CACK = 2'd3;
	localparam logic [2:0] QUERY_PHASE_CODE = 3'd4;

	typedef enum logic [2:0] {
		ACT_TRIGGER  = 3'd0,
		ACT_UP_COLL  = 3'd1,
		ACT_UP_IDLE  = 3'd2,
		ACT_UP_DATA  = 3'd3,
		ACT_DN_COLL  = 3'd4,
		ACT_CARRIER  = 3'd5,
		ACT_RESET    = 3'd6,
		ACT_NONE     = 3'd7
	} action_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] resp_reader;
		logic [7:0] data_reader;
		logic [7:0] data_control;
		logic [7:0] data_round;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT
	} back_state_t;
endpackage

/* design/samac_if.sv */
// Valid/ready channel interfaces
interface samac_in_if;
	import samac_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface samac_out_if;
	import samac_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface samac_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* design/samac_front.sv */
// Input stage: drops ignorable items and queues the rest
module samac_front (
	input  logic clk,
	input  logic arst_n,
	samac_in_if.sink in_ch,
	input  logic deq,
	output logic q_valid,
	output samac_pkg::item_t q_item
);
	import samac_pkg::*;

	item_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, keep;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign keep = (in_ch.data.action != ACT_NONE);
	assign push = in_ch.valid && in_ch.ready && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (deq) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(deq && q_valid);
		end
	end
endmodule

/* design/samac_back.sv */
// Execution stage: protocol state, pair table and frame streaming
module samac_back #(
	parameter int MAX_PAIRS = samac_pkg::MAX_PAIRS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] own_address,
	input  logic q_valid,
	input  samac_pkg::item_t q_item,
	output logic deq,
	samac_out_if.source out_ch
);
	import samac_pkg::*;
	localparam int PW = $clog2(MAX_PAIRS + 1);
	localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int LEN_MAX = 5 + 3 * MAX_PAIRS;
	localparam int BW = $clog2(LEN_MAX + 1);

	logic       qp_q, qp_snap_q;
	logic [1:0] ack_q, ack_snap_q;
	logic [7:0] slot_q, slot_snap_q, fsz_q, fsz_snap_q, coll_q, coll_snap_q;
	logic [7:0] rnd_q, rnd_snap_q;
	logic [PW-1:0] pc_q, pc_snap_q;
	logic [7:0] prd_q [MAX_PAIRS], prd_snap_q [MAX_PAIRS];
	logic [3:0] ptg_q [MAX_PAIRS], ptg_snap_q [MAX_PAIRS];
	logic [7:0] prn_q [MAX_PAIRS], prn_snap_q [MAX_PAIRS];

	// frame latched at trigger
	logic [7:0] h_own_q, h1_q, h2_q, h3_q;
	logic       f_qp_q;
	logic [BW-1:0] bi_q, blen_q;
	back_state_t st_q, st_d;

	logic mine, known, ostall, start;
	logic [7:0] slot_inc, byte_d;
	logic [IW-1:0] pi_q;
	logic [1:0] ps_q;

	assign mine = (q_item.resp_reader == own_address);
	assign slot_inc = slot_q + 8'd1;
	assign ostall = out_ch.valid && !out_ch.ready;

	always_comb begin
		known = 1'b0;
		for (int i = 0; i < MAX_PAIRS; i++)
			if (PW'(i) < pc_q && prd_q[i] == q_item.data_reader
				&& ptg_q[i] == q_item.data_control[7:4]) known = 1'b1;
	end

	always_comb begin
		st_d = st_q;
		deq = 1'b0;
		start = 1'b0;
		unique case (st_q)
			ST_IDLE: if (q_valid && !ostall) begin
				deq = 1'b1;
				if (q_item.action == ACT_TRIGGER) begin
					start = 1'b1;
					st_d = ST_EMIT;
				end
			end
			ST_EMIT: if (!ostall && bi_q == blen_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// byte bi_q: 0..3 header, then pairs, then trailing zero
	// pi_q/ps_q track pair and byte within pair alongside bi_q
	always_comb begin
		byte_d = 8'd0;
		priority if (bi_q == BW'(0)) byte_d = h_own_q;
		else if (bi_q == BW'(1)) byte_d = h1_q;
		else if (bi_q == BW'(2)) byte_d = h2_q;
		else if (bi_q == BW'(3)) byte_d = f_qp_q ? 8'd0 : h3_q;
		else if (bi_q == blen_q) byte_d = 8'd0;
		else begin
			unique case (ps_q)
				2'd0: byte_d = prd_snap_q[pi_q];
				2'd1: byte_d = {4'd0, ptg_snap_q[pi_q]};
				default: byte_d = prn_snap_q[pi_q];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_ch.valid <= 1'b0;
			bi_q <= '0;
			pi_q <= '0;
			ps_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_EMIT && !ostall) begin
				out_ch.valid <= 1'b1;
				out_ch.data.frame_byte <= byte_d;
				out_ch.data.frame_last <= (bi_q == blen_q);
				bi_q <= (bi_q == blen_q) ? '0 : bi_q + BW'(1);
				if (bi_q == blen_q) begin
					pi_q <= '0;
					ps_q <= '0;
				end else if (bi_q >= BW'(4)) begin
					if (ps_q == 2'd2) begin
						ps_q <= 2'd0;
						pi_q <= pi_q + IW'(1);
					end else
						ps_q <= ps_q + 2'd1;
				end
			end else if (out_ch.valid && out_ch.ready) begin
				out_ch.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qp_q <= 1'b0; ack_q <= NACK; slot_q <= '0; fsz_q <= 8'd1;
			coll_q <= '0; rnd_q <= '0; pc_q <= '0;
			qp_snap_q <= 1'b0; ack_snap_q <= NACK; slot_snap_q <= '0;
			fsz_snap_q <= 8'd1; coll_snap_q <= '0; rnd_snap_q <= '0; pc_snap_q <= '0;
			for (int i = 0; i < MAX_PAIRS; i++) begin
				prd_q[i] <= '0; ptg_q[i] <= '0; prn_q[i] <= '0;
				prd_snap_q[i] <= '0; ptg_snap_q[i] <= '0; prn_snap_q[i] <= '0;
			end
		end else if (deq) begin
			unique case (action_t'(q_item.action))
				ACT_TRIGGER: begin
					qp_snap_q <= qp_q; ack_snap_q <= ack_q; slot_snap_q <= slot_q;
					fsz_snap_q <= fsz_q; coll_snap_q <= coll_q; rnd_snap_q <= rnd_q;
					pc_snap_q <= pc_q;
					for (int i = 0; i < MAX_PAIRS; i++) begin
						prd_snap_q[i] <= prd_q[i]; ptg_snap_q[i] <= ptg_q[i];
						prn_snap_q[i] <= prn_q[i];
					end
					if (!qp_q) begin
						rnd_q <= rnd_q + 8'd1;
						pc_q <= '0; coll_q <= '0; slot_q <= '0;
						for (int i = 0; i < MAX_PAIRS; i++) begin
							prd_q[i] <= '0; ptg_q[i] <= '0; prn_q[i] <= '0;
						end
					end
				end
				ACT_UP_COLL, ACT_UP_IDLE: if (mine) begin
					if (q_item.action == ACT_UP_COLL) coll_q <= coll_q + 8'd1;
					if (slot_inc == fsz_q) begin
						qp_q <= 1'b0;
						slot_q <= fsz_q - 8'd1;
						// count wrapping to zero restarts at size 1
						if (q_item.action == ACT_UP_COLL)
							fsz_q <= (coll_q == 8'hFF) ? 8'd1
								: {coll_q[6:0] + 7'd1, 1'b0};
						else
							fsz_q <= (coll_q == 8'd0) ? 8'd1 : {coll_q[6:0], 1'b0};
					end else begin
						qp_q <= 1'b1;
						slot_q <= slot_inc;
					end
					ack_q <= (q_item.action == ACT_UP_COLL) ? CACK : NACK;
				end
				ACT_UP_DATA: if (mine) begin
					ack_q <= ACK;
					if (slot_inc >= fsz_q) begin
						qp_q <= 1'b0;
						slot_q <= fsz_q;
						fsz_q <= (coll_q == 8'd0) ? 8'd1 : {coll_q[6:0], 1'b0};
					end else begin
						qp_q <= 1'b1;
						slot_q <= slot_inc;
					end
				end else if (!known && pc_q < PW'(MAX_PAIRS)) begin
					prd_q[IW'(pc_q)] <= q_item.data_reader;
					ptg_q[IW'(pc_q)] <= q_item.data_control[7:4];
					prn_q[IW'(pc_q)] <= q_item.data_round;
					pc_q <= pc_q + PW'(1);
				end
				ACT_DN_COLL, ACT_CARRIER: begin
					qp_q <= qp_snap_q; ack_q <= ack_snap_q; slot_q <= slot_snap_q;
					fsz_q <= fsz_snap_q; coll_q <= coll_snap_q; rnd_q <= rnd_snap_q;
					pc_q <= pc_snap_q;
					for (int i = 0; i < MAX_PAIRS; i++) begin
						prd_q[i] <= prd_snap_q[i]; ptg_q[i] <= ptg_snap_q[i];
						prn_q[i] <= prn_snap_q[i];
					end
				end
				ACT_RESET: begin
					qp_q <= 1'b0; ack_q <= NACK; slot_q <= '0; fsz_q <= 8'd1;
					coll_q <= '0; rnd_q <= '0; pc_q <= '0;
					qp_snap_q <= 1'b0; ack_snap_q <= NACK; slot_snap_q <= '0;
					fsz_snap_q <= 8'd1; coll_snap_q <= '0; rnd_snap_q <= '0;
					pc_snap_q <= '0;
					for (int i = 0; i < MAX_PAIRS; i++) begin
						prd_q[i] <= '0; ptg_q[i] <= '0; prn_q[i] <= '0;
						prd_snap_q[i] <= '0; ptg_snap_q[i] <= '0; prn_snap_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// frame header captured at trigger
	always_ff @(posedge clk) begin
		if (start) begin
			h_own_q <= own_address;
			f_qp_q <= qp_q;
			h1_q <= {(qp_q ? 4'd4 : 4'd0) + {2'b00, ack_q}, 4'd0} + slot_q;
			h2_q <= qp_q ? rnd_q : rnd_q + 8'd1;
			h3_q <= {coll_q[3:0], 4'd0} + 8'(pc_q) * 8'd3;
			blen_q <= qp_q ? BW'(3) : BW'(4) + BW'(pc_q) * BW'(3);
		end
	end
endmodule

/* design/slotted_aloha_reader_mac_core.sv */
// Top level of the slotted ALOHA reader MAC core
// Output: once a trigger is dequeued, its frame streams one byte a cycle while
// the receiver is ready (4 bytes in query phase, 5+3*pairs in discovery).
// Flow: 1 non-trigger item per cycle in the back stage unless the output stalls; a
// trigger holds it to the end of its frame. A 2-entry queue parts front and back.
// Reset: arst_n clears all protocol state, snapshot, queue and own_address to defaults.
`include "assert_macros.svh"
module slotted_aloha_reader_mac_core #(
	parameter int MAX_PAIRS = samac_pkg::MAX_PAIRS_DEF
) (
	input logic clk,
	input logic arst_n,
	samac_in_if.sink in_ch,
	samac_out_if.source out_ch,
	samac_cfg_if.sink cfg
);
	import samac_pkg::*;

	logic [7:0] own_q;
	logic q_valid, deq;
	item_t q_item;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) own_q <= '0;
		else if (cfg.valid) own_q <= cfg.data;
	end

	samac_front u_front (.clk, .arst_n, .in_ch, .deq, .q_valid, .q_item);
	samac_back #(.MAX_PAIRS(MAX_PAIRS)) u_back (
		.clk, .arst_n, .own_address(own_q), .q_valid, .q_item, .deq, .out_ch);

	`CHK_IMPL(a_deq_valid, clk, arst_n, deq, q_valid)
	`CHK_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the slotted ALOHA reader MAC core
module tb_top;
	import samac_pkg::*;

	localparam int NPAIR = MAX_PAIRS_DEF;
	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		bit       query;
		bit [1:0] ack;
		bit [7:0] slot;
		bit [7:0] fsize;
		bit [7:0] colls;
		bit [7:0] rnd;
		int       npairs;
		bit [7:0] p_rd[NPAIR];
		bit [3:0] p_tg[NPAIR];
		bit [7:0] p_rn[NPAIR];
	} mac_state_t;

	class frame_scoreboard;
		bit [7:0]   own;
		mac_state_t live, saved;
		result_t    frame_q[$];
		int         errors;

		function mac_state_t fresh();
			mac_state_t s;
			s.query = 0; s.ack = NACK; s.slot = 0; s.fsize = 1;
			s.colls = 0; s.rnd = 0; s.npairs = 0;
			for (int i = 0; i < NPAIR; i++) begin
				s.p_rd[i] = 0; s.p_tg[i] = 0; s.p_rn[i] = 0;
			end
			return s;
		endfunction

		function void clear();
			own = 0; live = fresh(); saved = fresh(); frame_q.delete(); errors = 0;
		endfunction

		function void push_byte(bit [7:0] b, bit last);
			result_t r;
			r.frame_byte = b;
			r.frame_last = last;
			frame_q.push_back(r);
		endfunction

		function void advance_slot(bit [1:0] code, bit is_data);
			bit done;
			live.slot = live.slot + 8'd1;
			done = is_data ? (live.slot >= live.fsize) : (live.slot == live.fsize);
			if (done) begin
				live.query = 0;
				live.ack = code;
				live.slot = is_data ? live.fsize : live.fsize - 8'd1;
				live.fsize = (live.colls != 0) ? 8'(live.colls << 1) : 8'd1;
			end else begin
				live.query = 1;
				live.ack = code;
			end
		endfunction

		function bit known(bit [7:0] rd, bit [3:0] tg);
			for (int i = 0; i < live.npairs; i++)
				if (live.p_rd[i] == rd && live.p_tg[i] == tg) return 1;
			return 0;
		endfunction

		function void note_input(item_t it);
			bit       mine;
			bit [7:0] hdr;
			bit [7:0] phase;
			mine = (it.resp_reader == own);
			case (action_t'(it.action))
				ACT_TRIGGER: begin
					saved = live;
					phase = live.query ? 8'(QUERY_PHASE_CODE) : 8'd0;
					hdr = 8'(((phase + 8'(live.ack)) << 4) + live.slot);
					push_byte(own, 0);
					push_byte(hdr, 0);
					if (live.query) begin
						push_byte(live.rnd, 0);
						push_byte(8'd0, 1);
					end else begin
						live.rnd = live.rnd + 8'd1;
						push_byte(live.rnd, 0);
						push_byte(8'((live.colls << 4) + 3 * live.npairs), 0);
						for (int i = 0; i < live.npairs; i++) begin
							push_byte(live.p_rd[i], 0);
							push_byte(8'(live.p_tg[i]), 0);
							push_byte(live.p_rn[i], 0);
						end
						push_byte(8'd0, 1);
						for (int i = 0; i < NPAIR; i++) begin
							live.p_rd[i] = 0; live.p_tg[i] = 0; live.p_rn[i] = 0;
						end
						live.npairs = 0;
						live.colls = 0;
						live.slot = 0;
					end
				end
				ACT_UP_COLL: if (mine) begin
					live.colls = live.colls + 8'd1;
					advance_slot(CACK, 0);
				end
				ACT_UP_IDLE: if (mine) advance_slot(NACK, 0);
				ACT_UP_DATA: begin
					if (mine) advance_slot(ACK, 1);
					else if (!known(it.data_reader, it.data_control[7:4])
							&& live.npairs < NPAIR) begin
						live.p_rd[live.npairs] = it.data_reader;
						live.p_tg[live.npairs] = it.data_control[7:4];
						live.p_rn[live.npairs] = it.data_round;
						live.npairs++;
					end
				end
				ACT_DN_COLL, ACT_CARRIER: live = saved;
				ACT_RESET: begin
					live = fresh();
					saved = fresh();
				end
				default: ;
			endcase
		endfunction

		function void check_byte(result_t got);
			result_t want;
			if (frame_q.size() == 0) begin
				$error("unexpected frame byte %0h last %0b", got.frame_byte, got.frame_last);
				errors++;
				return;
			end
			want = frame_q.pop_front();
			if (got.frame_byte !== want.frame_byte) begin
				$error("frame_byte expected %0h actual %0h", want.frame_byte, got.frame_byte);
				errors++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last expected %0b actual %0b", want.frame_last, got.frame_last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	samac_in_if  in_ch();
	samac_out_if out_ch();
	samac_cfg_if cfg();

	slotted_aloha_reader_mac_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always #5 clk = ~clk;

	frame_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_off = 0;
	int quiet = 0;

	// receiver: random stalls, plus a counted long hold-off on request
	initial begin
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				out_ch.ready <= 0;
				hold_off--;
			end else
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) sb.check_byte(out_ch.data);
		if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)
				|| (cfg.valid && cfg.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("[slotted_aloha_reader_mac_core] ERROR");
			$finish;
		end
	end

	function item_t mk(action_t a, bit [7:0] resp, bit [7:0] rd, bit [7:0] ctl, bit [7:0] rn);
		item_t it;
		it.action = a;
		it.resp_reader = resp;
		it.data_reader = rd;
		it.data_control = ctl;
		it.data_round = rn;
		return it;
	endfunction

	// called at a falling edge; leaves valid high on return
	task send(item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(it);
		@(negedge clk);
	endtask

	task drain();
		in_ch.valid <= 0;
		while (sb.frame_q.size() != 0) @(posedge clk);
		repeat (40) @(negedge clk);
	endtask

	task set_address(bit [7:0] a);
		cfg.valid <= 1;
		cfg.data <= a;
		do @(posedge clk); while (!cfg.ready);
		sb.own = a;
		@(negedge clk);
		cfg.valid <= 0;
		@(negedge clk);
	endtask

	function item_t rand_item();
		action_t  a;
		bit [7:0] resp;
		bit [7:0] rd;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 12) a = ACT_TRIGGER;
		else if (pick < 32) a = ACT_UP_COLL;
		else if (pick < 50) a = ACT_UP_IDLE;
		else if (pick < 85) a = ACT_UP_DATA;
		else if (pick < 90) a = ACT_DN_COLL;
		else if (pick < 95) a = ACT_CARRIER;
		else if (pick < 98) a = ACT_RESET;
		else a = ACT_NONE;
		resp = ($urandom_range(99) < 60) ? sb.own : 8'($urandom);
		// narrow reader range makes duplicate pairs common
		rd = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
		return mk(a, resp, rd, 8'($urandom), 8'($urandom));
	endfunction

	initial begin
		int idles[4] = '{0, 57, 0, 17};
		int stalls[4] = '{0, 0, 57, 17};
		bit [7:0] addrs[4];
		in_ch.valid = 0;
		in_ch.data = '0;
		cfg.valid = 0;
		cfg.data = '0;
		sb.clear();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset-time address, then extremes and special cases
		send(mk(ACT_TRIGGER, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_UP_DATA, 8'hFF, 8'hFF, 8'hF0, 8'hFF));
		send(mk(ACT_UP_DATA, 8'h01, 8'hFF, 8'hFF, 8'h00));
		send(mk(ACT_UP_IDLE, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_UP_COLL, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_UP_COLL, 8'h05, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_TRIGGER, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_DN_COLL, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_UP_DATA, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send(mk(ACT_TRIGGER, 8'h00, 8'h00, 8'h00, 8'h00));
		for (int i = 0; i < NPAIR + 1; i++)
			send(mk(ACT_UP_DATA, 8'h80, 8'(i + 16), 8'(i << 4), 8'(i * 29)));
		send(mk(ACT_TRIGGER, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_CARRIER, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_TRIGGER, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_RESET, 8'h00, 8'h00, 8'h00, 8'h00));
		send(mk(ACT_TRIGGER, 8'h00, 8'h00, 8'h00, 8'h00));
		drain();

		addrs = '{8'hFF, 8'($urandom), 8'h00, 8'($urandom)};
		for (int ph = 0; ph < 4; ph++) begin
			set_address(addrs[ph]);
			idle_pct = idles[ph];
			stall_pct = stalls[ph];
			if (ph == 0) begin
				// long receiver hold-off while triggers keep coming
				hold_off = 300;
				for (int i = 0; i < 12; i++)
					send(mk(ACT_TRIGGER, sb.own, 8'($urandom), 8'($urandom), 8'($urandom)));
				drain();
			end
			if (ph == 1) begin
				// collision count past 128 so the frame size wraps
				for (int i = 0; i < 130; i++)
					send(mk(ACT_UP_COLL, sb.own, 8'($urandom), 8'($urandom), 8'($urandom)));
				send(mk(ACT_UP_IDLE, sb.own, 8'h00, 8'h00, 8'h00));
				send(mk(ACT_TRIGGER, sb.own, 8'h00, 8'h00, 8'h00));
				send(mk(ACT_TRIGGER, sb.own, 8'h00, 8'h00, 8'h00));
			end
			for (int i = 0; i < 10; i++) begin
				send(rand_item());
				if (i == 5) drain();
			end
			drain();
		end

		if (sb.errors == 0)
			$display("[slotted_aloha_reader_mac_core] OK");
		else
			$display("[slotted_aloha_reader_mac_core] ERROR");
		$finish;
	end
endmodule
